>>> rtl/core/bfts_pkg.sv
// Shared constants, types and helper functions of the tour search core.
`default_nettype none

package bfts_pkg;

	// Largest number of cities the core is built for.
	localparam int MAX_CITIES = 8;
	// Number of low bits of an edge cost that the cost table keeps.
	localparam int COST_BITS = 16;

	// Derived widths and the cost table depth.
	localparam int CITY_W  = $clog2(MAX_CITIES);
	localparam int POS_W   = $clog2(MAX_CITIES + 1);
	localparam int ADDR_W  = $clog2(MAX_CITIES * MAX_CITIES);
	localparam int DEPTH   = MAX_CITIES * MAX_CITIES;

	// Fixed widths of the configuration word and of the item and result word fields.
	localparam int CFG_W   = 4;
	localparam int EDGE_W  = 16;
	localparam int SUM_W   = 20;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [CFG_W-1:0] CITY_COUNT_RESET = CFG_W'(4);

	typedef logic [MAX_CITIES-1:0][CITY_W-1:0] order_t;

	typedef struct packed {
		logic init;
		logic step;
	} perm_ctrl_t;

	typedef struct packed {
		order_t order;
		logic   more;
	} perm_stat_t;

	function automatic order_t identity_order();
		order_t o;
		for (int k = 0; k < MAX_CITIES; k++) begin
			o[k] = CITY_W'(k);
		end
		return o;
	endfunction

	function automatic logic [ADDR_W-1:0] cost_addr(
		input logic [CITY_W-1:0] row,
		input logic [CITY_W-1:0] col
	);
		return ADDR_W'(int'(row) * MAX_CITIES + int'(col));
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/bfts_if.sv
// Handshake interfaces for the matrix entry words and the tour result words.
`default_nettype none

interface bfts_item_if;
	logic                           valid;
	logic                           ready;
	logic [bfts_pkg::CITY_W-1:0]    from_city;
	logic [bfts_pkg::CITY_W-1:0]    to_city;
	logic [bfts_pkg::EDGE_W-1:0]    edge_cost;
	logic                           last_entry;

	modport source (output valid, from_city, to_city, edge_cost, last_entry, input ready);
	modport sink (input valid, from_city, to_city, edge_cost, last_entry, output ready);
endinterface

interface bfts_result_if;
	logic                           valid;
	logic                           ready;
	logic [bfts_pkg::POS_W-1:0]     tour_position;
	logic [bfts_pkg::CITY_W-1:0]    tour_city;
	logic [bfts_pkg::SUM_W-1:0]     tour_cost;
	logic                           tour_end;

	modport source (output valid, tour_position, tour_city, tour_cost, tour_end, input ready);
	modport sink (input valid, tour_position, tour_city, tour_cost, tour_end, output ready);
endinterface

`default_nettype wire

>>> rtl/core/brute_force_tour_search_core.sv
// Exhaustive tour search core: loads a cost matrix and emits the cheapest closed tour.
// Matrix words load one per cycle. The word flagged last starts a search that walks every
// order of the n-1 inner cities, reading one edge per cycle from the single cost table port
// and then closing and comparing each tour in a drain step.
// The n+1 result words then leave one per cycle while the sink is ready; no word is taken
// meanwhile. Reset is asynchronous: control, orders, best cost and city count (to 4) reset,
// while the cost table keeps its contents and is undefined until written.
`default_nettype none

module brute_force_tour_search_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [bfts_pkg::CFG_W-1:0] cfg_wr_data,
	bfts_item_if.sink                       item,
	bfts_result_if.source                   result
);

	typedef enum logic [1:0] {
		S_LOAD,
		S_SUM,
		S_DRAIN,
		S_EMIT
	} state_t;

	state_t                         state_q;
	logic [bfts_pkg::CFG_W-1:0]     city_count_q;
	logic [bfts_pkg::POS_W-1:0]     n_q;
	logic [bfts_pkg::CITY_W-1:0]    edge_q;
	logic                           pend_q;
	logic [bfts_pkg::SUM_W-1:0]     sum_q;
	logic [bfts_pkg::SUM_W-1:0]     best_q;
	bfts_pkg::order_t               best_order_q;
	logic                           found_q;
	logic [bfts_pkg::POS_W-1:0]     pos_q;

	logic                           item_acc;
	logic                           start;
	logic                           wr_en;
	logic [bfts_pkg::ADDR_W-1:0]    wr_addr;
	logic [bfts_pkg::COST_BITS-1:0] wr_data;
	logic [bfts_pkg::ADDR_W-1:0]    rd_addr;
	logic [bfts_pkg::COST_BITS-1:0] rd_data;
	logic [bfts_pkg::SUM_W:0]       add_wide;
	logic [bfts_pkg::SUM_W-1:0]     add_sat;
	logic                           last_edge;
	logic                           take_tour;
	logic [bfts_pkg::POS_W-1:0]     n_used;
	logic [bfts_pkg::CITY_W-1:0]    to_idx;
	bfts_pkg::perm_ctrl_t           perm_ctrl;
	bfts_pkg::perm_stat_t           perm_stat;

	// Only the load state takes words; a word with last_entry set kicks off the search.
	assign item.ready = (state_q == S_LOAD);
	assign item_acc   = item.valid && item.ready;
	assign start      = item_acc && item.last_entry;

	// Rows or columns beyond the built size are dropped.
	assign wr_en   = item_acc && (int'(item.from_city) < bfts_pkg::MAX_CITIES)
		&& (int'(item.to_city) < bfts_pkg::MAX_CITIES);
	assign wr_addr = bfts_pkg::cost_addr(item.from_city, item.to_city);
	assign wr_data = bfts_pkg::COST_BITS'(item.edge_cost);

	bfts_ram #(
		.WIDTH (bfts_pkg::COST_BITS),
		.DEPTH (bfts_pkg::DEPTH)
	) u_cost_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// A city count of zero means one city, and anything past the built size is clamped.
	always_comb begin
		if (city_count_q == '0) begin
			n_used = bfts_pkg::POS_W'(1);
		end else if (int'(city_count_q) > bfts_pkg::MAX_CITIES) begin
			n_used = bfts_pkg::POS_W'(bfts_pkg::MAX_CITIES);
		end else begin
			n_used = bfts_pkg::POS_W'(city_count_q);
		end
	end

	// The sequencer walks the edges of the current tour one per cycle. The last edge of the
	// tour returns to city 0.
	assign last_edge = (bfts_pkg::POS_W'(edge_q) + bfts_pkg::POS_W'(1)) == n_q;
	assign to_idx    = last_edge ? '0 : perm_stat.order[bfts_pkg::CITY_W'(edge_q + 1'b1)];
	assign rd_addr   = bfts_pkg::cost_addr(perm_stat.order[edge_q], to_idx);

	// The one shared saturating adder, fed by the registered table read.
	assign add_wide = (bfts_pkg::SUM_W+1)'(sum_q) + (bfts_pkg::SUM_W+1)'(rd_data);
	assign add_sat  = add_wide[bfts_pkg::SUM_W] ? bfts_pkg::SUM_MAX
		: add_wide[bfts_pkg::SUM_W-1:0];

	// Strict compare keeps the first minimum; the first tour of a search is always kept.
	assign take_tour = !found_q || (add_sat < best_q);

	assign perm_ctrl.init = start;
	assign perm_ctrl.step = (state_q == S_DRAIN);

	bfts_perm u_perm (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (perm_ctrl),
		.n      (n_q),
		.stat   (perm_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			city_count_q <= bfts_pkg::CITY_COUNT_RESET;
			n_q          <= bfts_pkg::POS_W'(1);
			edge_q       <= '0;
			pend_q       <= 1'b0;
			sum_q        <= '0;
			best_q       <= bfts_pkg::SUM_MAX;
			best_order_q <= bfts_pkg::identity_order();
			found_q      <= 1'b0;
			pos_q        <= '0;
		end else begin
			if (cfg_wr_en) begin
				city_count_q <= cfg_wr_data;
			end
			case (state_q)
				S_LOAD: begin
					if (start) begin
						n_q     <= n_used;
						edge_q  <= '0;
						pend_q  <= 1'b0;
						sum_q   <= '0;
						best_q  <= bfts_pkg::SUM_MAX;
						found_q <= 1'b0;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					// Add the edge read in the previous cycle while the next one is read.
					if (pend_q) begin
						sum_q <= add_sat;
					end
					pend_q <= 1'b1;
					if (last_edge) begin
						state_q <= S_DRAIN;
					end else begin
						edge_q <= edge_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (take_tour) begin
						best_q       <= add_sat;
						best_order_q <= perm_stat.order;
						found_q      <= 1'b1;
					end
					edge_q <= '0;
					pend_q <= 1'b0;
					sum_q  <= '0;
					if (perm_stat.more) begin
						state_q <= S_SUM;
					end else begin
						pos_q   <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (result.ready) begin
						if (pos_q == n_q) begin
							state_q <= S_LOAD;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Result words come straight from the held best tour; the closing word names city 0.
	assign result.valid         = (state_q == S_EMIT);
	assign result.tour_position = pos_q;
	assign result.tour_city     = (pos_q == n_q) ? '0
		: best_order_q[bfts_pkg::CITY_W'(pos_q)];
	assign result.tour_cost     = best_q;
	assign result.tour_end      = (pos_q == n_q);

	// The core never takes a word while results are on offer.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(item.ready && result.valid))
		else $error("word taken while results pending");

	// A search always ends with at least one tour kept.
	a_found_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> found_q)
		else $error("results shown without a kept tour");

	// The emit position never runs past the closing word.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (pos_q <= n_q))
		else $error("result position out of range");

	// Taking the closing word returns the core to loading.
	a_end_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && result.tour_end) |=> item.ready)
		else $error("core not back to loading after last result");

	// A last entry always starts the edge walk on the next cycle.
	a_start_search: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == S_SUM) && (edge_q == '0))
		else $error("search did not start");

endmodule

`default_nettype wire

>>> rtl/core/bfts_ram.sv
// Generic single write port RAM with one registered read port.
`default_nettype none

module bfts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/core/bfts_perm.sv
// Current visiting order and its step to the next lexicographic permutation.
`default_nettype none

module bfts_perm (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire bfts_pkg::perm_ctrl_t       ctrl,
	input  wire logic [bfts_pkg::POS_W-1:0] n,
	output      bfts_pkg::perm_stat_t       stat
);

	bfts_pkg::order_t order_q;
	bfts_pkg::order_t nxt;
	logic             found;

	// Inner cities sit at positions 1..n-1; position 0 always holds city 0.
	always_comb begin
		logic [bfts_pkg::CITY_W-1:0] i_pos;
		logic [bfts_pkg::CITY_W-1:0] j_pos;
		bfts_pkg::order_t            b;
		int                          n_int;
		n_int = int'(n);
		found = 1'b0;
		i_pos = '0;
		for (int k = 1; k <= bfts_pkg::MAX_CITIES - 2; k++) begin
			if ((k + 1 < n_int) && (order_q[k] < order_q[k + 1])) begin
				found = 1'b1;
				i_pos = bfts_pkg::CITY_W'(k);
			end
		end
		j_pos = i_pos;
		for (int k = 1; k < bfts_pkg::MAX_CITIES; k++) begin
			if ((k < n_int) && (k > int'(i_pos)) && (order_q[k] > order_q[i_pos])) begin
				j_pos = bfts_pkg::CITY_W'(k);
			end
		end
		b = order_q;
		b[i_pos] = order_q[j_pos];
		b[j_pos] = order_q[i_pos];
		nxt = b;
		for (int k = 1; k < bfts_pkg::MAX_CITIES; k++) begin
			if ((k > int'(i_pos)) && (k < n_int)) begin
				nxt[k] = b[bfts_pkg::CITY_W'(int'(i_pos) + n_int - k)];
			end
		end
		// Wrapping past the last order gives back the identity order.
		if (!found) begin
			nxt = bfts_pkg::identity_order();
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= bfts_pkg::identity_order();
		end else if (ctrl.init) begin
			order_q <= bfts_pkg::identity_order();
		end else if (ctrl.step) begin
			order_q <= nxt;
		end
	end

	assign stat.order = order_q;
	assign stat.more  = found;

endmodule

`default_nettype wire
